// File: src/tcba_pkg.sv
// Shared types and constants for the two-channel block averager.
// No dependencies.
package tcba_pkg;

  localparam int IN_W  = 12;  // converter word field width
  localparam int TAG_W = 4;   // channel tag / channel id width
  localparam int OUT_W = 12;  // average field width
  localparam int CFG_W = 4;   // widest config register
  localparam int IDX_W = 1;   // two config registers

  localparam logic [IDX_W-1:0] REG_FIRST_ID  = 1'b0;
  localparam logic [IDX_W-1:0] REG_SECOND_ID = 1'b1;

  localparam logic [TAG_W-1:0] FIRST_ID_RST  = 4'd0;
  localparam logic [TAG_W-1:0] SECOND_ID_RST = 4'd4;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // input side ready
    logic acc;     // word accepted, accumulate it
    logic load;    // snapshot sums into divider, clear window
    logic step;    // one quotient bit
    logic push;    // commit averages to output register
  } tcba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained
  } tcba_status_t;

endpackage

// File: src/tcba_in_if.sv
// Input word channel: converter sample, channel tag, window end mark.
// Depends on tcba_pkg.
interface tcba_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcba_pkg::IN_W-1:0]     sample_value;
  logic [tcba_pkg::TAG_W-1:0]    channel_tag;
  logic                          window_last;

  modport source (output valid, sample_value, channel_tag, window_last, input ready);
  modport sink   (input valid, sample_value, channel_tag, window_last, output ready);
endinterface

// File: src/tcba_out_if.sv
// Result word channel: both channel averages and the window fault flag.
// Depends on tcba_pkg.
interface tcba_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcba_pkg::OUT_W-1:0]    first_average;
  logic [tcba_pkg::OUT_W-1:0]    second_average;
  logic                          window_fault;

  modport source (output valid, first_average, second_average, window_fault, input ready);
  modport sink   (input valid, first_average, second_average, window_fault, output ready);
endinterface

// File: src/tcba_ctrl.sv
// Sequencing controller: accumulate, load, divide, push.
// Depends on tcba_pkg.
module tcba_ctrl #(
  parameter int SUM_W = 18
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_last,
  input  tcba_pkg::tcba_status_t status,
  output tcba_pkg::tcba_cmd_t    cmd
);
  import tcba_pkg::*;

  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  localparam logic [1:0] S_ACC  = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]        state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      S_ACC: begin
        cmd.accept = 1'b1;
        cmd.acc    = in_valid;
        if (in_valid && in_last) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load      = 1'b1;
        step_cnt_next = STEP_W'(SUM_W - 1);
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt - 1'b1;
        if (step_cnt == '0) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_ACC;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

endmodule

// File: src/tcba_datapath.sv
// Datapath: channel id registers, per-channel sum/count accumulators,
// two-lane restoring divider, stored averages and result register.
// Depends on tcba_pkg.
module tcba_datapath #(
  parameter int MAX_WINDOW  = 64,
  parameter int EFF_BITS    = 12,
  parameter int CNT_W       = 7,
  parameter int SUM_W       = 19
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tcba_pkg::IDX_W-1:0] cfg_index,
  input  logic [tcba_pkg::CFG_W-1:0] cfg_data,
  input  logic [tcba_pkg::IN_W-1:0]  sample_value,
  input  logic [tcba_pkg::TAG_W-1:0] channel_tag,
  input  tcba_pkg::tcba_cmd_t        cmd,
  output tcba_pkg::tcba_status_t     status,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [tcba_pkg::OUT_W-1:0] first_average,
  output logic [tcba_pkg::OUT_W-1:0] second_average,
  output logic                       window_fault
);
  import tcba_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW);

  logic [TAG_W-1:0] first_id, second_id;
  logic [SUM_W-1:0] first_sum, second_sum;
  logic [CNT_W-1:0] first_count, second_count;
  logic             fault_seen;

  // divider lanes: dividend shifts out, quotient shifts in
  logic [SUM_W-1:0] first_q, second_q;
  logic [CNT_W-1:0] first_dvs, second_dvs;
  logic [CNT_W-1:0] first_rem, second_rem;
  logic             first_empty, second_empty;
  logic             fault_cap;

  logic [OUT_W-1:0] first_mean, second_mean;
  logic             fault_out;
  logic             out_full;

  logic [SUM_W-1:0] sample_ext;
  logic             hit_first, hit_second;
  logic [CNT_W:0]   first_sh, second_sh;
  logic             first_bit, second_bit;

  assign sample_ext = SUM_W'(sample_value[EFF_BITS-1:0]);
  assign hit_first  = (channel_tag == first_id);
  assign hit_second = (channel_tag == second_id);

  assign first_sh   = {first_rem, first_q[SUM_W-1]};
  assign second_sh  = {second_rem, second_q[SUM_W-1]};
  assign first_bit  = (first_sh >= {1'b0, first_dvs});
  assign second_bit = (second_sh >= {1'b0, second_dvs});

  assign status.out_free = !out_full || out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_id  <= FIRST_ID_RST;
      second_id <= SECOND_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_ID:  first_id  <= cfg_data[TAG_W-1:0];
        REG_SECOND_ID: second_id <= cfg_data[TAG_W-1:0];
        default: ;
      endcase
    end
  end

  // window accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      first_sum    <= '0;
      second_sum   <= '0;
      first_count  <= '0;
      second_count <= '0;
      fault_seen   <= 1'b0;
    end else if (cmd.acc) begin
      if (hit_first && first_count < CNT_MAX) begin
        first_sum   <= first_sum + sample_ext;
        first_count <= first_count + 1'b1;
      end
      if (hit_second && second_count < CNT_MAX) begin
        second_sum   <= second_sum + sample_ext;
        second_count <= second_count + 1'b1;
      end
      if (!hit_first && !hit_second) begin
        fault_seen <= 1'b1;
      end
    end
  end

  // divider, one quotient bit per lane per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_q      <= first_sum;
      second_q     <= second_sum;
      first_dvs    <= first_count;
      second_dvs   <= second_count;
      first_rem    <= '0;
      second_rem   <= '0;
      first_empty  <= (first_count == '0);
      second_empty <= (second_count == '0);
      fault_cap    <= fault_seen;
    end else if (cmd.step) begin
      first_q    <= {first_q[SUM_W-2:0], first_bit};
      second_q   <= {second_q[SUM_W-2:0], second_bit};
      first_rem  <= first_bit ? CNT_W'(first_sh - {1'b0, first_dvs}) : first_sh[CNT_W-1:0];
      second_rem <= second_bit ? CNT_W'(second_sh - {1'b0, second_dvs})
                               : second_sh[CNT_W-1:0];
    end
  end

  // stored averages double as the result payload
  always_ff @(posedge clk) begin
    if (rst) begin
      first_mean  <= '0;
      second_mean <= '0;
      fault_out   <= 1'b0;
      out_full    <= 1'b0;
    end else if (cmd.push) begin
      if (!first_empty) begin
        first_mean <= OUT_W'(first_q);
      end
      if (!second_empty) begin
        second_mean <= OUT_W'(second_q);
      end
      fault_out <= fault_cap;
      out_full  <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  assign out_valid      = out_full;
  assign first_average  = first_mean;
  assign second_average = second_mean;
  assign window_fault   = fault_out;

endmodule

// File: src/two_channel_block_averager.sv
// Top level of the two-channel block averager.
// Depends on tcba_pkg, tcba_in_if, tcba_out_if, tcba_ctrl, tcba_datapath.
//
// Takes one converter word per cycle while a window is open, summing and
// counting samples whose tag matches first_channel_id or second_channel_id
// (cfg index 0 and 1; a tag matching both feeds both). A tag matching
// neither sets the window fault. Per channel, at most MAX_WINDOW samples
// count per window; later ones are dropped silently. When the word marked
// window_last is accepted, the input stalls while both channel sums are
// divided by their counts in a two-lane restoring divider, one quotient bit
// per cycle: window close runs a load state, the divide steps and a push
// state that waits while the previous result has not been taken. A channel
// with no samples keeps its previous average; averages reset to zero. The
// result sits in an output register, so the next window runs while the
// result waits.
// Only the low min(SAMPLE_BITS, 12) bits of sample_value are used.
module two_channel_block_averager #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tcba_pkg::IDX_W-1:0] cfg_index,
  input  logic [tcba_pkg::CFG_W-1:0] cfg_data,
  tcba_in_if.sink                    in_word,
  tcba_out_if.source                 out_word
);
  import tcba_pkg::*;

  // effective sample width: the input field carries 12 bits at most
  localparam int EFF_BITS = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
  // count must hold MAX_WINDOW itself
  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
  // sum of MAX_WINDOW samples of EFF_BITS bits
  localparam int SUM_W    = EFF_BITS + CNT_W;

  tcba_cmd_t    cmd;
  tcba_status_t status;

  assign in_word.ready = cmd.accept;

  tcba_ctrl #(
    .SUM_W (SUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_word.valid),
    .in_last  (in_word.window_last),
    .status   (status),
    .cmd      (cmd)
  );

  tcba_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .EFF_BITS    (EFF_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_value   (in_word.sample_value),
    .channel_tag    (in_word.channel_tag),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_word.ready),
    .out_valid      (out_word.valid),
    .first_average  (out_word.first_average),
    .second_average (out_word.second_average),
    .window_fault   (out_word.window_fault)
  );

  // closing word is followed by the divider load
  a_last_loads: assert property (@(posedge clk) disable iff (rst)
    in_word.valid && in_word.ready && in_word.window_last |=> cmd.load)
    else $error("window end not followed by divider load");

  // no word taken while the divider is loaded
  a_load_stalls: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !in_word.ready)
    else $error("input accepted during divider load");

  // a push never overwrites an untaken result
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_word.valid || out_word.ready))
    else $error("result overwritten before taken");

  // a push always presents a result next cycle
  a_push_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> out_word.valid)
    else $error("push did not raise result valid");

endmodule
